[src/gbdf_pkg.sv]
// ----------------------------------------------------------------------------
// gbdf_pkg
// Shared types and constants of the grid distance-field block: item kinds,
// neighbour directions and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gbdf_pkg;

    // field widths fixed by the item format
    localparam int COORD_W = 6;
    localparam int DIST_W  = 12;
    localparam logic [DIST_W-1:0] DIST_MAX = 12'd4095;

    // item kinds
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // neighbour visiting order
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic vclr_step;
        logic take_item;
        logic obs_write;
        logic dist_read;
        logic start_search;
        logic level_adv;
        logic pop_read;
        logic cell_load;
        logic nbr_read;
        logic nbr_check;
        logic nbr_next;
        logic out_load;
    } gbdf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       sweep_last;
        logic [1:0] kind;
        logic       oob;
        logic       q_empty;
        logic       lvl_end;
        logic       nbr_in;
        logic       d_last;
        logic       out_free;
    } gbdf_stat_t;

endpackage

[src/gbdf_ctrl.sv]
// ----------------------------------------------------------------------------
// gbdf_ctrl
// Sequencer of the distance-field block: reset sweep, item dispatch,
// visited clear, level-by-level search loop and result hand-off.
// ----------------------------------------------------------------------------
module gbdf_ctrl
    import gbdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  gbdf_stat_t stat,
    output gbdf_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_VCLR,
        S_START,
        S_POP,
        S_CELL,
        S_NRD,
        S_NCHK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.kind == KIND_NONE || stat.oob)
                    state_next = S_RESP;
                else if (stat.kind == KIND_SET)
                begin
                    cmd.obs_write = 1'b1;
                    state_next    = S_RESP;
                end
                else if (stat.kind == KIND_SEARCH)
                    state_next = S_VCLR;
                else
                begin
                    cmd.dist_read = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_VCLR:
            begin
                cmd.vclr_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.start_search = 1'b1;
                state_next       = S_POP;
            end
            S_POP:
            begin
                if (stat.q_empty)
                    state_next = S_RESP;
                else if (stat.lvl_end)
                    cmd.level_adv = 1'b1;
                else
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_CELL;
                end
            end
            S_CELL:
            begin
                cmd.cell_load = 1'b1;
                state_next    = S_NRD;
            end
            S_NRD:
            begin
                if (stat.nbr_in)
                begin
                    cmd.nbr_read = 1'b1;
                    state_next   = S_NCHK;
                end
                else
                begin
                    cmd.nbr_next = 1'b1;
                    if (stat.d_last)
                        state_next = S_POP;
                end
            end
            S_NCHK:
            begin
                cmd.nbr_check = 1'b1;
                cmd.nbr_next  = 1'b1;
                state_next    = stat.d_last ? S_POP : S_NRD;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

[src/gbdf_datapath.sv]
// ----------------------------------------------------------------------------
// gbdf_datapath
// Maps, frontier queue, search counters and output register of the
// distance-field block, driven by the controller's commands.
// ----------------------------------------------------------------------------
module gbdf_datapath
    import gbdf_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         kind,
    input  logic [COORD_W-1:0] cell_x,
    input  logic [COORD_W-1:0] cell_y,
    input  logic               obstacle_bit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIST_W-1:0]  distance,
    output logic               status,
    input  gbdf_cmd_t          cmd,
    output gbdf_stat_t         stat
);

    localparam int XW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int N  = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int QW = XW + YW;

    // memories
    logic              obstacle_mem [N];
    logic              visited_mem  [N];
    logic [DIST_W-1:0] distance_mem [N];
    logic [QW-1:0]     queue_mem    [N];

    logic              obs_rd_reg;
    logic              vis_rd_reg;
    logic [DIST_W-1:0] dist_rd_reg;
    logic [QW-1:0]     q_rd_reg;

    // item and search registers
    logic [1:0]        kind_reg;
    logic [XW-1:0]     item_x_reg;
    logic [YW-1:0]     item_y_reg;
    logic              item_bit_reg;
    logic              oob_reg;
    logic [AW-1:0]     sweep_reg;
    logic [CW-1:0]     head_reg, tail_reg, lend_reg;
    logic [DIST_W-1:0] level_reg;
    logic [XW-1:0]     cur_x_reg;
    logic [YW-1:0]     cur_y_reg;
    logic [1:0]        dir_reg;
    logic [XW-1:0]     nbr_x_reg;
    logic [YW-1:0]     nbr_y_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              status_reg;

    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          nbr_in;
    logic          in_oob;
    logic [AW-1:0] item_idx, nbr_idx, nbr_reg_idx, pop_idx;
    logic [XW-1:0] pop_x;
    logic [YW-1:0] pop_y;
    logic          push_ok;

    function automatic logic [AW-1:0] cell_index(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
        cell_index = AW'(32'(y) * 32'(GRID_WIDTH) + 32'(x));
    endfunction

    // bounds check on incoming coordinates
    assign in_oob = ({3'b000, cell_x} >= 9'(GRID_WIDTH))
                 || ({3'b000, cell_y} >= 9'(GRID_HEIGHT));

    assign pop_x       = q_rd_reg[XW-1:0];
    assign pop_y       = q_rd_reg[QW-1:XW];
    assign item_idx    = cell_index(item_x_reg, item_y_reg);
    assign pop_idx     = cell_index(pop_x, pop_y);
    assign nbr_idx     = cell_index(nx, ny);
    assign nbr_reg_idx = cell_index(nbr_x_reg, nbr_y_reg);
    assign push_ok     = !vis_rd_reg && !obs_rd_reg && (tail_reg < CW'(N));

    // neighbour of the current cell in the current direction
    always_comb
    begin
        nx     = cur_x_reg;
        ny     = cur_y_reg;
        nbr_in = 1'b0;
        case (dir_reg)
            DIR_DOWN:
            begin
                ny     = cur_y_reg + YW'(1);
                nbr_in = (cur_y_reg != YW'(GRID_HEIGHT - 1));
            end
            DIR_UP:
            begin
                ny     = cur_y_reg - YW'(1);
                nbr_in = (cur_y_reg != '0);
            end
            DIR_LEFT:
            begin
                nx     = cur_x_reg - XW'(1);
                nbr_in = (cur_x_reg != '0);
            end
            DIR_RIGHT:
            begin
                nx     = cur_x_reg + XW'(1);
                nbr_in = (cur_x_reg != XW'(GRID_WIDTH - 1));
            end
            default:
            begin
                nbr_in = 1'b0;
            end
        endcase
    end

    // obstacle map
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            obstacle_mem[sweep_reg] <= 1'b0;
        else if (cmd.obs_write)
            obstacle_mem[item_idx] <= item_bit_reg;
        if (cmd.nbr_read)
            obs_rd_reg <= obstacle_mem[nbr_idx];
    end

    // visited map
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step || cmd.vclr_step)
            visited_mem[sweep_reg] <= 1'b0;
        else if (cmd.start_search)
            visited_mem[item_idx] <= 1'b1;
        else if (cmd.nbr_check && push_ok)
            visited_mem[nbr_reg_idx] <= 1'b1;
        if (cmd.nbr_read)
            vis_rd_reg <= visited_mem[nbr_idx];
    end

    // distance map
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            distance_mem[sweep_reg] <= '0;
        else if (cmd.cell_load)
            distance_mem[pop_idx] <= level_reg;
        if (cmd.dist_read)
            dist_rd_reg <= distance_mem[item_idx];
    end

    // frontier queue
    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
            queue_mem[AW'(0)] <= {item_y_reg, item_x_reg};
        else if (cmd.nbr_check && push_ok)
            queue_mem[tail_reg[AW-1:0]] <= {nbr_y_reg, nbr_x_reg};
        if (cmd.pop_read)
            q_rd_reg <= queue_mem[head_reg[AW-1:0]];
    end

    // item, cell and neighbour payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            kind_reg     <= kind;
            item_x_reg   <= XW'(cell_x);
            item_y_reg   <= YW'(cell_y);
            item_bit_reg <= obstacle_bit;
            oob_reg      <= in_oob;
        end
        if (cmd.cell_load)
        begin
            cur_x_reg <= pop_x;
            cur_y_reg <= pop_y;
        end
        if (cmd.nbr_read)
        begin
            nbr_x_reg <= nx;
            nbr_y_reg <= ny;
        end
        if (cmd.out_load)
        begin
            distance_reg <= (kind_reg == KIND_READ && !oob_reg) ? dist_rd_reg : '0;
            status_reg   <= oob_reg && (kind_reg != KIND_NONE);
        end
    end

    // sweep, queue pointers, level and direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            lend_reg  <= '0;
            level_reg <= '0;
            dir_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step || cmd.vclr_step)
                sweep_reg <= (sweep_reg == AW'(N - 1)) ? '0 : sweep_reg + AW'(1);
            if (cmd.start_search)
            begin
                head_reg  <= '0;
                tail_reg  <= CW'(1);
                lend_reg  <= CW'(1);
                level_reg <= '0;
            end
            if (cmd.level_adv)
            begin
                lend_reg <= tail_reg;
                if (level_reg != DIST_MAX)
                    level_reg <= level_reg + DIST_W'(1);
            end
            if (cmd.pop_read)
                head_reg <= head_reg + CW'(1);
            if (cmd.nbr_check && push_ok)
                tail_reg <= tail_reg + CW'(1);
            if (cmd.cell_load)
                dir_reg <= DIR_DOWN;
            else if (cmd.nbr_next)
                dir_reg <= dir_reg + 2'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign status    = status_reg;

    // status to the controller
    assign stat.sweep_last = (sweep_reg == AW'(N - 1));
    assign stat.kind       = kind_reg;
    assign stat.oob        = oob_reg;
    assign stat.q_empty    = (head_reg == tail_reg);
    assign stat.lvl_end    = (head_reg == lend_reg);
    assign stat.nbr_in     = nbr_in;
    assign stat.d_last     = (dir_reg == DIR_RIGHT);
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

[src/grid_bfs_distance_field.sv]
// ----------------------------------------------------------------------------
// grid_bfs_distance_field
// Obstacle map and four-neighbour breadth-first distance map of a grid.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall with kind, cell_x, cell_y,
// obstacle_bit) and one output channel (out_valid/out_stall with distance,
// status). Every accepted item gives exactly one result transaction.
// After reset the block sweeps the obstacle, distance and visited maps to
// zero, one cell a cycle, with in_stall high. Configuration-free.
// Set obstacle, read distance, ignored item: the item passes the dispatch
// and response states and its result is then loaded into the output
// register; the next item is taken only after that load.
// Search: one visited-map sweep, then per reached cell a pop and a cell
// load, a read and a check per in-grid neighbour, a skip step per edge
// side, and a level-advance step per level. The single port of each map
// memory sets this order of steps. One item is processed at a time.
// A finished result sits in the output register; the next item is taken
// while it waits, and its result is held back until out_stall drops.
// ----------------------------------------------------------------------------
module grid_bfs_distance_field
    import gbdf_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [COORD_W-1:0] cell_x,
    input  logic [COORD_W-1:0] cell_y,
    input  logic               obstacle_bit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIST_W-1:0]  distance,
    output logic               status
);

    gbdf_cmd_t  cmd;
    gbdf_stat_t stat;

    // sequencer
    gbdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // maps, queue and output register
    gbdf_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .obstacle_bit (obstacle_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

[src/gbdf_checker.sv]
// ----------------------------------------------------------------------------
// gbdf_checker
// Port-level checks of the distance-field block, bound to the top level.
// ----------------------------------------------------------------------------
module gbdf_checker
    import gbdf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         kind,
    input logic [COORD_W-1:0] cell_x,
    input logic [COORD_W-1:0] cell_y,
    input logic               obstacle_bit,
    input logic               out_valid,
    input logic               out_stall,
    input logic [DIST_W-1:0]  distance,
    input logic               status
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(distance) && $stable(status))
        else $error("result payload changed while stalled");

    // an out-of-grid item carries no distance
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> distance == '0)
        else $error("out-of-grid result with nonzero distance");

    // one item at a time: input closes right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in work");

endmodule

bind grid_bfs_distance_field gbdf_checker u_chk (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_bfs_distance_field: a queue-fed driver offers
// obstacle writes, searches and distance reads with random gaps, a monitor
// stalls at random and compares each result transaction with a grid model.
// ----------------------------------------------------------------------------
module testbench;
    import gbdf_pkg::*;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int CELLS = GW * GH;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] kind;
        logic [5:0] x;
        logic [5:0] y;
        logic       blk;
    } grid_op_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        logic              stat;
    } grid_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = KIND_NONE;
    logic [COORD_W-1:0] cell_x = '0;
    logic [COORD_W-1:0] cell_y = '0;
    logic               obstacle_bit = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DIST_W-1:0]  distance;
    logic               status;

    grid_op_t  pending_ops[$];
    grid_res_t expected_res[$];
    int        errors = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;

    // grid model state
    bit                obst_map[CELLS];
    logic [DIST_W-1:0] dist_map[CELLS];
    bit                seen_map[CELLS];
    int                frontier[CELLS];

    grid_bfs_distance_field u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .cell_x(cell_x), .cell_y(cell_y),
        .obstacle_bit(obstacle_bit),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .status(status)
    );

    always #10 clk = ~clk;

    // breadth-first fill of the distance map from a start cell
    function void flood_distances(int sx, int sy);
        int head, tail, lend, c, cx, cy, nx, ny, n, d;
        logic [DIST_W-1:0] lvl;
        int dx[4];
        int dy[4];
        dx = '{0, 0, -1, 1};
        dy = '{1, -1, 0, 0};
        head = 0;
        tail = 0;
        for (int i = 0; i < CELLS; i++) seen_map[i] = 0;
        frontier[tail++] = sy * GW + sx;
        lvl = 0;
        while (head < tail)
        begin
            lend = tail;
            while (head < lend)
            begin
                c = frontier[head++];
                cx = c % GW;
                cy = c / GW;
                seen_map[c] = 1;
                dist_map[c] = lvl;
                for (d = 0; d < 4; d++)
                begin
                    nx = cx + dx[d];
                    ny = cy + dy[d];
                    if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
                    n = ny * GW + nx;
                    if (seen_map[n] || obst_map[n] || tail >= CELLS) continue;
                    frontier[tail++] = n;
                    seen_map[n] = 1;
                end
            end
            if (lvl < DIST_MAX) lvl++;
        end
    endfunction

    // apply one transaction to the model and return its expected result
    function grid_res_t grid_result(grid_op_t op);
        grid_res_t r;
        int idx;
        r.dist_val = '0;
        r.stat = 1'b0;
        if (op.kind == KIND_NONE) return r;
        if (op.x >= GW || op.y >= GH)
        begin
            r.stat = 1'b1;
            return r;
        end
        idx = op.y * GW + op.x;
        if (op.kind == KIND_SET) obst_map[idx] = op.blk;
        else if (op.kind == KIND_SEARCH) flood_distances(op.x, op.y);
        else r.dist_val = dist_map[idx];
        return r;
    endfunction

    function grid_op_t make_op(logic [1:0] k, int x, int y, bit b);
        grid_op_t op;
        op.kind = k;
        op.x = 6'(x);
        op.y = 6'(y);
        op.blk = b;
        return op;
    endfunction

    // append one pending transaction
    function void queue_op(logic [1:0] k, int x, int y, bit b);
        pending_ops = {pending_ops, make_op(k, x, y, b)};
    endfunction

    // driver: per-transaction gap, bursts with no gap every other 16 items
    int  send_gap = 0;
    int  sent = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_res = {expected_res, grid_result(pending_ops.pop_front())};
                sent++;
                send_gap = ((sent / 16) % 2) ? 0 : $urandom_range(0, 14);
                nv = 1'b0;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    nv = 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    nv = 1'b1;
                    kind <= pending_ops[0].kind;
                    cell_x <= pending_ops[0].x;
                    cell_y <= pending_ops[0].y;
                    obstacle_bit <= pending_ops[0].blk;
                end
                else nv = 1'b0;
            end
            in_valid <= nv;
        end
    end

    // monitor: compare against oldest expectation, random stall per result
    int hold_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        grid_res_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_res.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result distance=%0d status=%0d",
                             $time, distance, status);
                end
                else
                begin
                    e = expected_res.pop_front();
                    if (distance !== e.dist_val)
                    begin
                        errors++;
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, e.dist_val, distance);
                    end
                    if (status !== e.stat)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.stat, status);
                    end
                end
                // long hold-off once so the block backs up its input
                hold_cnt = (results_seen == 30) ? 600 :
                           (((results_seen / 16) % 2) ? 0 : $urandom_range(0, 14));
            end
            else if (hold_cnt > 0) hold_cnt--;
            out_stall <= (hold_cnt > 0);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] k;
        int r;
        for (int i = 0; i < CELLS; i++)
        begin
            obst_map[i] = 0;
            dist_map[i] = '0;
            seen_map[i] = 0;
        end
        // directed: reads at reset, corner obstacles, searches, unused kind
        queue_op(KIND_READ, 0, 0, 0);
        queue_op(KIND_READ, 63, 63, 1);
        queue_op(KIND_SEARCH, 0, 0, 0);
        queue_op(KIND_READ, 63, 63, 0);
        queue_op(KIND_READ, 63, 0, 0);
        queue_op(KIND_SET, 1, 0, 1);
        queue_op(KIND_SET, 0, 1, 1);
        queue_op(KIND_SET, 63, 63, 1);
        queue_op(KIND_SET, 63, 63, 0);
        queue_op(KIND_SEARCH, 32, 32, 1);
        queue_op(KIND_READ, 0, 0, 0);
        queue_op(KIND_READ, 63, 63, 0);
        // blocked start cell still gets distance zero
        queue_op(KIND_SET, 10, 20, 1);
        queue_op(KIND_SEARCH, 10, 20, 0);
        queue_op(KIND_READ, 10, 20, 0);
        queue_op(KIND_READ, 0, 0, 0);
        queue_op(KIND_NONE, 63, 63, 1);
        queue_op(KIND_NONE, 0, 0, 0);
        queue_op(KIND_SET, 1, 0, 0);
        queue_op(KIND_SET, 0, 1, 0);
        // random: walls and obstacles, searches now and then, many reads
        for (int i = 0; i < 60; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 8) k = KIND_SET;
            else if (r < 10) k = KIND_SEARCH;
            else if (r < 19) k = KIND_READ;
            else k = KIND_NONE;
            if (k == KIND_SET && $urandom_range(0, 3) == 0)
            begin
                // six obstacle writes in one random column, at random rows
                r = $urandom_range(0, 63);
                for (int j = 0; j < 6; j++)
                    queue_op(KIND_SET, r, $urandom_range(0, 63),
                             $urandom_range(0, 3) != 0);
            end
            else
                queue_op(k, $urandom_range(0, 63), $urandom_range(0, 63),
                         1'($urandom_range(0, 1)));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
src/gbdf_pkg.sv
src/gbdf_ctrl.sv
src/gbdf_datapath.sv
src/grid_bfs_distance_field.sv
src/gbdf_checker.sv
test/testbench.sv
